@@ sv/gcsl_pkg.sv @@
package gcsl_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_WORD  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] VERDICT_SEARCH     = 2'd0;
  localparam logic [1:0] VERDICT_MEMBER     = 2'd1;
  localparam logic [1:0] VERDICT_NOT_MEMBER = 2'd2;

  // results per word before the rest of the buffer waits for the next word
  localparam logic [1:0] MAX_CODES = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPARE,
    ST_FLUSH
  } gcsl_state_t;

  typedef struct packed {
    logic start;      // clear decoder, load key
    logic append;     // add the word to the bit buffer
    logic absorb;     // buffer is all zeros: fold it into the zero run
    logic strip;      // drop up to 8 leading zeros
    logic decode;     // take one code off the buffer
    logic pend_code;  // hold the decoded value with its verdict
    logic pend_none;  // hold a verdict-only not-member result
    logic push;       // move the held result to the output register
    logic push_last;  // mark the pushed result as last
  } gcsl_cmd_t;

  typedef struct packed {
    logic       set_empty;
    logic       buf_zero;
    logic       buf_lsb;
    logic       held_short;
    logic       out_free;
    logic [1:0] verdict;
  } gcsl_stat_t;

endpackage

@@ sv/gcsl_if.sv @@
interface gcsl_query_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] key;
  logic [31:0] word;

  modport source (output valid, kind, key, word, input ready);
  modport sink (input valid, kind, key, word, output ready);
endinterface

interface gcsl_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        has_value;
  logic [1:0]  verdict;
  logic        last;

  modport source (output valid, value, has_value, verdict, last, input ready);
  modport sink (input valid, value, has_value, verdict, last, output ready);
endinterface

interface gcsl_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/golomb_coded_set_lookup.sv @@
// A start or end item's verdict is held on acceptance, then pushed from the flush state.
// A word is appended on acceptance; for each code the scan strips the zeros ahead of it (up to
// 8 a cycle), decodes it and compares it, then a closing scan follows unless the word ends on a
// verdict or its third code, then a flush; pushes wait for a free out reg.
// One item at a time: the next item is accepted once the word's last result
// sits in the output register. Reset (rst, synchronous): idle, not searching, set_size 0.
module golomb_coded_set_lookup #(
  parameter int REMAINDER_BITS = 10
) (
  input logic                 clk,
  input logic                 rst,
  gcsl_cfg_if.sink            cfg,
  gcsl_query_if.sink          query,
  gcsl_result_if.source       result
);
  import gcsl_pkg::*;

  gcsl_cmd_t  cmd;
  gcsl_stat_t stat;

  assign cfg.ready = 1'b1;

  gcsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (query.valid),
    .in_kind  (query.kind),
    .in_ready (query.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcsl_dpath #(
    .REMAINDER_BITS (REMAINDER_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .key           (query.key),
    .word          (query.word),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.data),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .out_value     (result.value),
    .out_has_value (result.has_value),
    .out_verdict   (result.verdict),
    .out_last      (result.last)
  );

endmodule

@@ sv/gcsl_ctrl.sv @@
module gcsl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  input  gcsl_pkg::gcsl_stat_t stat,
  output gcsl_pkg::gcsl_cmd_t  cmd
);
  import gcsl_pkg::*;

  gcsl_state_t state, state_next;
  logic        searching, searching_next;
  logic        pend_valid, pend_valid_next;
  logic [1:0]  n_codes, n_codes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      searching  <= 1'b0;
      pend_valid <= 1'b0;
      n_codes    <= '0;
    end else begin
      state      <= state_next;
      searching  <= searching_next;
      pend_valid <= pend_valid_next;
      n_codes    <= n_codes_next;
    end
  end

  always_comb begin
    state_next      = state;
    searching_next  = searching;
    pend_valid_next = pend_valid;
    n_codes_next    = n_codes;
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_kind)
            KIND_START: begin
              cmd.start = 1'b1;
              if (stat.set_empty) begin
                cmd.pend_none   = 1'b1;
                pend_valid_next = 1'b1;
                searching_next  = 1'b0;
                state_next      = ST_FLUSH;
              end else begin
                searching_next = 1'b1;
              end
            end
            KIND_END: begin
              if (searching) begin
                cmd.pend_none   = 1'b1;
                pend_valid_next = 1'b1;
                searching_next  = 1'b0;
                state_next      = ST_FLUSH;
              end
            end
            KIND_WORD: begin
              if (searching) begin
                cmd.append   = 1'b1;
                n_codes_next = '0;
                state_next   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.buf_zero) begin
          cmd.absorb = 1'b1;
          state_next = ST_FLUSH;
        end else if (stat.buf_lsb) begin
          if (stat.held_short) begin
            state_next = ST_FLUSH;  // code incomplete, wait for more bits
          end else begin
            cmd.decode = 1'b1;
            state_next = ST_COMPARE;
          end
        end else begin
          cmd.strip = 1'b1;
        end
      end
      ST_COMPARE: begin
        // the held result is not last, since another code followed it
        if (!pend_valid || stat.out_free) begin
          cmd.push        = pend_valid;
          cmd.pend_code   = 1'b1;
          pend_valid_next = 1'b1;
          n_codes_next    = n_codes + 2'd1;
          if (stat.verdict != VERDICT_SEARCH) begin
            searching_next = 1'b0;
            state_next     = ST_FLUSH;
          end else if (n_codes + 2'd1 == MAX_CODES) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push        = 1'b1;
          cmd.push_last   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/gcsl_dpath.sv @@
module gcsl_dpath #(
  parameter int REMAINDER_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  gcsl_pkg::gcsl_cmd_t  cmd,
  output gcsl_pkg::gcsl_stat_t stat,
  input  logic [63:0]       key,
  input  logic [31:0]       word,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [31:0]       out_value,
  output logic              out_has_value,
  output logic [1:0]        out_verdict,
  output logic              out_last
);
  import gcsl_pkg::*;

  localparam int CODE_BITS = REMAINDER_BITS + 1;

  logic [31:0] set_size;
  logic [63:0] bit_buffer;
  logic [6:0]  bits_held;
  logic [31:0] zero_run;
  logic [31:0] running_sum;
  logic [31:0] codes_done;
  logic [63:0] search_key;
  logic [31:0] dec_value;
  logic [31:0] pend_value;
  logic        pend_has;
  logic [1:0]  pend_verdict;

  logic [3:0]  strip_amt;
  logic [31:0] code_value;
  logic [1:0]  verdict;

  function automatic logic [3:0] tz8(input logic [7:0] b);
    logic [3:0] t;
    t = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) t = 4'(i);
    end
    return t;
  endfunction

  assign strip_amt  = tz8(bit_buffer[7:0]);
  assign code_value = running_sum + 32'(zero_run << REMAINDER_BITS)
                      + 32'(bit_buffer[REMAINDER_BITS:1]);

  always_comb begin
    if ({32'b0, dec_value} == search_key) verdict = VERDICT_MEMBER;
    else if ({32'b0, dec_value} > search_key) verdict = VERDICT_NOT_MEMBER;
    else if (codes_done >= set_size) verdict = VERDICT_NOT_MEMBER;
    else verdict = VERDICT_SEARCH;
  end

  always_comb begin
    stat.set_empty  = (set_size == '0);
    stat.buf_zero   = (bit_buffer == '0);
    stat.buf_lsb    = bit_buffer[0];
    stat.held_short = (bits_held < 7'(CODE_BITS));
    stat.out_free   = !out_valid || out_ready;
    stat.verdict    = verdict;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size <= '0;
    end else if (cfg_valid) begin
      set_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bit_buffer  <= '0;
      bits_held   <= '0;
      zero_run    <= '0;
      running_sum <= '0;
      codes_done  <= '0;
      search_key  <= key;
    end else if (cmd.append) begin
      // word is dropped if the buffer cannot take all 32 bits
      if (bits_held <= 7'd32) begin
        bit_buffer <= bit_buffer | ({32'b0, word} << bits_held);
        bits_held  <= bits_held + 7'd32;
      end
    end else if (cmd.absorb) begin
      zero_run  <= zero_run + 32'(bits_held);
      bits_held <= '0;
    end else if (cmd.strip) begin
      bit_buffer <= bit_buffer >> strip_amt;
      bits_held  <= bits_held - 7'(strip_amt);
      zero_run   <= zero_run + 32'(strip_amt);
    end else if (cmd.decode) begin
      bit_buffer  <= bit_buffer >> CODE_BITS;
      bits_held   <= bits_held - 7'(CODE_BITS);
      dec_value   <= code_value;
      running_sum <= code_value;
      zero_run    <= '0;
      codes_done  <= codes_done + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_code) begin
      pend_value   <= dec_value;
      pend_has     <= 1'b1;
      pend_verdict <= verdict;
    end else if (cmd.pend_none) begin
      pend_value   <= '0;
      pend_has     <= 1'b0;
      pend_verdict <= VERDICT_NOT_MEMBER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_value     <= pend_value;
      out_has_value <= pend_has;
      out_verdict   <= pend_verdict;
      out_last      <= cmd.push_last;
    end
  end

endmodule

@@ sv/gcsl_check.sv @@
module gcsl_check (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_value,
  input logic        res_has_value,
  input logic [1:0]  res_verdict,
  input logic        res_last
);
  import gcsl_pkg::*;

  // a stalled item stays offered
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped while stalled");

  // verdict-only items are always a final not-member with no value
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_has_value |->
      res_verdict == VERDICT_NOT_MEMBER && res_last && res_value == '0)
    else $error("malformed verdict-only item");

  // a search ends with its verdict, so nothing follows it for that item
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_verdict != VERDICT_SEARCH |-> res_last)
    else $error("final verdict not marked last");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_verdict == VERDICT_SEARCH || res_verdict == VERDICT_MEMBER ||
                  res_verdict == VERDICT_NOT_MEMBER)
    else $error("undefined verdict code");

endmodule

bind golomb_coded_set_lookup gcsl_check u_check (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_value     (result.value),
  .res_has_value (result.has_value),
  .res_verdict   (result.verdict),
  .res_last      (result.last)
);

@@ bench/tb_golomb_coded_set_lookup.sv @@
`timescale 1ns / 100ps

module tb_golomb_coded_set_lookup;
  import gcsl_pkg::*;

  localparam int REM_BITS = 10;
  localparam logic [31:0] REM_MASK = (32'd1 << REM_BITS) - 32'd1;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 200;

  typedef struct packed {
    logic [31:0] value;
    logic        has_value;
    logic [1:0]  verdict;
    logic        last;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gcsl_cfg_if    cfg_if ();
  gcsl_query_if  q_if ();
  gcsl_result_if r_if ();

  golomb_coded_set_lookup #(
    .REMAINDER_BITS(REM_BITS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_if),
    .query (q_if),
    .result(r_if)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] set_size_reg;
  logic [63:0] bit_buf;
  int          held_bits;
  logic [31:0] zero_cnt;
  logic [31:0] sum_acc;
  logic [31:0] codes_seen;
  logic [63:0] search_for;
  logic        busy_search;

  lookup_res_t want_results[$];
  logic        code_bits[$];
  logic [31:0] stream_words[$];

  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  bit tx_pause_on = 1'b1;
  bit rx_pause_on = 1'b1;

  task automatic report(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_decoder();
    bit_buf = '0;
    held_bits = 0;
    zero_cnt = '0;
    sum_acc = '0;
    codes_seen = '0;
  endtask

  // Expected results of one accepted item, appended to want_results.
  task automatic decode_lookup(input logic [1:0] kind, input logic [63:0] key,
                               input logic [31:0] word);
    lookup_res_t batch[$];
    lookup_res_t r;
    int p;
    logic [31:0] rem;
    logic [31:0] val;
    logic [1:0] vd;
    case (kind)
      KIND_START: begin
        clear_decoder();
        search_for = key;
        busy_search = 1'b1;
        if (set_size_reg == 32'd0) begin
          busy_search = 1'b0;
          r = '{32'd0, 1'b0, VERDICT_NOT_MEMBER, 1'b0};
          batch = {batch, r};
        end
      end
      KIND_END: begin
        if (busy_search) begin
          busy_search = 1'b0;
          r = '{32'd0, 1'b0, VERDICT_NOT_MEMBER, 1'b0};
          batch = {batch, r};
        end
      end
      KIND_WORD: begin
        if (busy_search) begin
          if (held_bits <= 32) begin
            bit_buf = bit_buf | ({32'd0, word} << held_bits);
            held_bits += 32;
          end
          while (batch.size() < 3 && held_bits > 0) begin
            if (bit_buf == 64'd0) begin
              // whole buffer is zeros: fold into the pending quotient
              zero_cnt = zero_cnt + held_bits;
              held_bits = 0;
              break;
            end
            p = 0;
            while (bit_buf[p] == 1'b0) p++;
            zero_cnt = zero_cnt + p;
            bit_buf = bit_buf >> p;
            held_bits -= p;
            if (held_bits < 1 + REM_BITS) break;
            rem = 32'(bit_buf >> 1) & REM_MASK;
            bit_buf = bit_buf >> (1 + REM_BITS);
            held_bits -= 1 + REM_BITS;
            val = sum_acc + (zero_cnt << REM_BITS) + rem;
            sum_acc = val;
            zero_cnt = '0;
            codes_seen = codes_seen + 32'd1;
            if ({32'd0, val} == search_for) vd = VERDICT_MEMBER;
            else if ({32'd0, val} > search_for) vd = VERDICT_NOT_MEMBER;
            else if (codes_seen >= set_size_reg) vd = VERDICT_NOT_MEMBER;
            else vd = VERDICT_SEARCH;
            r = '{val, 1'b1, vd, 1'b0};
            batch = {batch, r};
            if (vd != VERDICT_SEARCH) begin
              busy_search = 1'b0;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) begin
      r = batch[i];
      want_results = {want_results, r};
    end
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [63:0] key,
                           input logic [31:0] word);
    int gap;
    gap = tx_pause_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      q_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    q_if.valid <= 1'b1;
    q_if.kind <= kind;
    q_if.key <= key;
    q_if.word <= word;
    do @(posedge clk); while (!q_if.ready);
    decode_lookup(kind, key, word);
    if (kind != KIND_NONE) items_sent++;
  endtask

  // Wait until every expected result is back and the block has settled.
  task automatic drain();
    q_if.valid <= 1'b0;
    while (want_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [31:0] n);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= n;
    do @(posedge clk); while (!cfg_if.ready);
    set_size_reg = n;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic add_code(input int q, input logic [31:0] r);
    for (int i = 0; i < q; i++) code_bits = {code_bits, 1'b0};
    code_bits = {code_bits, 1'b1};
    for (int i = 0; i < REM_BITS; i++) code_bits = {code_bits, r[i]};
  endtask

  // Pack code_bits LSB first into stream_words, zero padded.
  task automatic pack_words();
    logic [31:0] w;
    stream_words.delete();
    while (code_bits.size() > 0) begin
      w = '0;
      for (int b = 0; b < 32; b++)
        if (code_bits.size() > 0) w[b] = code_bits.pop_front();
      stream_words = {stream_words, w};
    end
  endtask

  task automatic test_idle_inputs();
    // set_size is still at its reset value of zero
    send_item(KIND_WORD, 64'd0, 32'hFFFF_FFFF);
    send_item(KIND_END, 64'd0, 32'd0);
    send_item(KIND_NONE, '1, '1);
    send_item(KIND_START, 64'd5, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'h0000_0001);
  endtask

  task automatic test_member_first_code();
    write_size('1);
    send_item(KIND_START, 64'd0, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'h0000_0001);
  endtask

  task automatic test_dense_and_zero_words();
    send_item(KIND_START, '1, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'hFFFF_FFFF);
    send_item(KIND_WORD, 64'd0, 32'hFFFF_FFFF);
    send_item(KIND_WORD, 64'd0, 32'h0000_0000);
    send_item(KIND_WORD, 64'd0, 32'h0000_0000);
    send_item(KIND_WORD, 64'd0, 32'h0000_0400);
    // leaves a partial code behind; the end item closes the search without decoding it
    send_item(KIND_END, 64'd0, 32'd0);
  endtask

  task automatic test_count_limit();
    write_size(32'd2);
    send_item(KIND_START, 64'h1_0000_0000, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_size_lowered();
    write_size('1);
    send_item(KIND_START, '1, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'h0000_0001);
    write_size(32'd1);
    send_item(KIND_WORD, 64'd0, 32'h0000_0001);
  endtask

  task automatic test_exceed_key();
    write_size('1);
    send_item(KIND_START, 64'd100, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'd1 | (32'd200 << 1));
  endtask

  task automatic test_zero_run_across_words();
    send_item(KIND_START, 64'd40000, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'd0);
    send_item(KIND_WORD, 64'd0, 32'd1 | (32'd5 << 1));
    send_item(KIND_END, 64'd0, 32'd0);
  endtask

  // Sink holds off for a long stretch while words keep coming back to back.
  task automatic test_output_backpressure();
    write_size('1);
    tx_pause_on = 1'b0;
    hold_req = LONG_HOLD;
    send_item(KIND_START, '1, 32'd0);
    for (int i = 0; i < 16; i++) send_item(KIND_WORD, 64'd0, $urandom | 32'd1);
    send_item(KIND_END, 64'd0, 32'd0);
    tx_pause_on = 1'b1;
    drain();
  endtask

  task automatic random_query();
    int ncodes;
    int q;
    logic [31:0] r;
    logic [31:0] acc;
    logic [31:0] vals[$];
    logic [63:0] key;
    logic [31:0] w;
    acc = '0;
    code_bits.delete();
    ncodes = $urandom_range(1, 10);
    for (int i = 0; i < ncodes; i++) begin
      q = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 3);
      r = $urandom_range(0, 1023);
      add_code(q, r);
      acc = acc + (q << REM_BITS) + r;
      vals = {vals, acc};
    end
    pack_words();
    case ($urandom_range(0, 5))
      0, 1: key = {32'd0, vals[$urandom_range(0, vals.size() - 1)]};
      2: key = {32'd0, vals[$urandom_range(0, vals.size() - 1)] + 32'd1};
      3: key = {32'd0, acc} + $urandom_range(1, 3000);
      4: key = {$urandom, $urandom};
      default: key = {32'd0, $urandom};
    endcase
    if ($urandom_range(0, 9) == 0) send_item(KIND_WORD, 64'd0, $urandom);
    send_item(KIND_START, key, $urandom);
    foreach (stream_words[i]) begin
      w = stream_words[i];
      if ($urandom_range(0, 11) == 0) w = $urandom;
      if ($urandom_range(0, 11) == 0) send_item(KIND_NONE, {$urandom, $urandom}, $urandom);
      send_item(KIND_WORD, {$urandom, $urandom}, w);
      if ($urandom_range(0, 19) == 0) break;
    end
    case ($urandom_range(0, 5))
      0: ;  // no end item, the next start clears the search
      1: begin
        send_item(KIND_END, 64'd0, 32'd0);
        send_item(KIND_END, 64'd0, 32'd0);
      end
      default: send_item(KIND_END, {$urandom, $urandom}, $urandom);
    endcase
  endtask

  task automatic test_random_queries();
    int target;
    target = items_sent + 120;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        tx_pause_on = ($urandom_range(0, 3) != 0);
        rx_pause_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: write_size(32'd0);
          1: write_size('1);
          2: write_size($urandom);
          default: write_size($urandom_range(1, 12));
        endcase
      end
      random_query();
    end
  endtask

  task automatic finish_run();
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    q_if.valid = 1'b0;
    q_if.kind = KIND_START;
    q_if.key = '0;
    q_if.word = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    clear_decoder();
    set_size_reg = '0;
    search_for = '0;
    busy_search = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_inputs();
    test_member_first_code();
    test_dense_and_zero_words();
    test_count_limit();
    test_size_lowered();
    test_exceed_key();
    test_zero_run_across_words();
    test_output_backpressure();
    test_random_queries();
    finish_run();
  end

  initial begin : result_sink
    int stall;
    r_if.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = rx_pause_on ? $urandom_range(0, 11) : 0;
      end
      if (stall > 0) begin
        r_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      r_if.ready <= 1'b1;
      do @(posedge clk); while (!r_if.valid);
    end
  end

  always @(posedge clk) begin : result_check
    lookup_res_t got;
    lookup_res_t exp_res;
    if (!rst && r_if.valid && r_if.ready) begin
      got = '{r_if.value, r_if.has_value, r_if.verdict, r_if.last};
      if (want_results.size() == 0) begin
        report($sformatf("result with nothing expected: value %0d verdict %0d",
                         got.value, got.verdict));
      end else begin
        exp_res = want_results.pop_front();
        if (got.value !== exp_res.value)
          report($sformatf("value %0d, expected %0d", got.value, exp_res.value));
        if (got.has_value !== exp_res.has_value)
          report($sformatf("has_value %0b, expected %0b", got.has_value, exp_res.has_value));
        if (got.verdict !== exp_res.verdict)
          report($sformatf("verdict %0d, expected %0d", got.verdict, exp_res.verdict));
        if (got.last !== exp_res.last)
          report($sformatf("last %0b, expected %0b", got.last, exp_res.last));
      end
    end
  end

  // no item moving on any channel for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (q_if.valid && q_if.ready) || (r_if.valid && r_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
